### hdl/lpb_pkg.sv
// Package for the LRU prefetch buffer: field widths, opcodes, result kinds
// and the queued command type shared by the front and back sections.
package lpb_pkg;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned FetchW = 17;
  localparam int unsigned TotW   = 48;
  localparam int unsigned OccW   = 5;
  localparam int unsigned CntW   = 13;

  typedef enum logic [1:0] {
    OP_ACCESS   = 2'd0,
    OP_PREFETCH = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_CAP   = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [IdxW-1:0] index;
    logic            oor;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FetchW-1:0] fetch_group;
    logic              evicted;
    logic [IdxW-1:0]   evicted_index;
    logic              hit;
    logic [3:0]        reuse_distance;
    logic [TotW-1:0]   total_reuse;
    logic [TotW-1:0]   reuse_hits;
    logic              range_err;
    logic              clamped;
    logic [OccW-1:0]   occupancy;
    logic              last;
  } res_t;
endpackage

### hdl/lpb_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on lpb_pkg.
interface lpb_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [lpb_pkg::IdxW-1:0] index;
  modport source (output valid, operation, index, input ready);
  modport sink   (input valid, operation, index, output ready);
endinterface

interface lpb_out_if;
  logic          valid;
  logic          ready;
  lpb_pkg::res_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/lpb_front.sv
// Front section: accepts items, range-checks accesses, and pushes commands
// into a two-entry queue. Depends on lpb_pkg and lpb_if.
module lpb_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lpb_in_if.sink                  in_ch,
  input  logic [lpb_pkg::CntW-1:0] count_i,
  output logic                    cmd_valid_o,
  output lpb_pkg::cmd_t           cmd_o,
  input  logic                    cmd_ready_i
);
  lpb_pkg::cmd_t q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  lpb_pkg::cmd_t c;

  assign in_ch.ready  = cnt_q != 2'd2;
  assign push         = in_ch.valid && in_ch.ready;
  assign cmd_valid_o  = cnt_q != 2'd0;
  assign pop          = cmd_valid_o && cmd_ready_i;
  assign cmd_o        = q_mem[rp_q];

  always_comb begin
    c.op    = in_ch.operation;
    c.index = in_ch.index;
    c.oor   = {1'b0, in_ch.index} >= count_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
endmodule

### hdl/lpb_back.sv
// Back section: LRU store, sequential search, reorder, prefetch walk, totals.
// Depends on lpb_pkg and lpb_if.
module lpb_back #(
  parameter int unsigned MAX_ENTRIES        = 16,
  parameter int unsigned MAX_PREFETCH_BURST = 63
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  lpb_pkg::cmd_t            cmd_i,
  output logic                     cmd_ready_o,
  input  logic [15:0]              base_i,
  input  logic [lpb_pkg::CntW-1:0] count_i,
  input  logic [4:0]               cap_i,
  lpb_out_if.source                out_ch
);
  localparam int unsigned PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BW = 6;
  localparam logic [lpb_pkg::TotW-1:0] TOT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_ACT, S_SHIFT, S_EMIT, S_PF
  } state_e;

  state_e state_q;
  lpb_pkg::cmd_t cmd_q;
  logic [lpb_pkg::CntW-1:0] lru_q [MAX_ENTRIES];
  logic [NW-1:0] n_q;
  logic [NW-1:0] pos_q;
  logic found_q;
  logic [NW-1:0] sh_q, sh_end_q;
  logic [lpb_pkg::CntW-1:0] key_q;
  logic [lpb_pkg::CntW-1:0] ptr_q, target_q;
  logic [BW-1:0] fetches_q;
  logic [lpb_pkg::TotW-1:0] sum_q, hits_q;
  logic ins_q, miss_reply_q;
  logic [1:0] after_q;
  lpb_pkg::res_t res_q, work_q;
  logic ov_q;

  localparam logic [1:0] A_DONE = 2'd0, A_PF = 2'd1;

  logic [NW-1:0] cap_eff;
  always_comb begin
    if (cap_i == 5'd0) cap_eff = NW'(1);
    else if ({27'd0, cap_i} > MAX_ENTRIES) cap_eff = NW'(MAX_ENTRIES);
    else cap_eff = NW'(cap_i);
  end

  logic match;
  assign match = lru_q[pos_q[PW-1:0]] == key_q;
  assign cmd_ready_o = state_q == S_IDLE;
  assign out_ch.valid = ov_q;
  assign out_ch.data  = res_q;

  logic [NW-1:0] depth_raw;
  logic [3:0] hit_depth;
  logic [lpb_pkg::TotW:0] sum_inc, hits_inc;
  logic [lpb_pkg::TotW-1:0] sum_sat, hits_sat;
  logic evict;
  assign depth_raw = n_q - NW'(1) - pos_q;
  assign hit_depth = (32'(depth_raw) > 32'd15) ? 4'd15 : 4'(depth_raw);
  assign sum_inc   = {1'b0, sum_q} + {{(lpb_pkg::TotW - 3){1'b0}}, hit_depth};
  assign hits_inc  = {1'b0, hits_q} + 49'd1;
  assign sum_sat   = sum_inc[lpb_pkg::TotW] ? TOT_MAX : sum_inc[lpb_pkg::TotW-1:0];
  assign hits_sat  = hits_inc[lpb_pkg::TotW] ? TOT_MAX : hits_inc[lpb_pkg::TotW-1:0];
  assign evict     = (n_q >= cap_eff) && (n_q != '0);

  function automatic lpb_pkg::res_t blank(input logic [NW-1:0] occ,
      input logic [lpb_pkg::TotW-1:0] s, input logic [lpb_pkg::TotW-1:0] h);
    lpb_pkg::res_t r;
    r = '0;
    r.total_reuse = s;
    r.reuse_hits = h;
    r.occupancy = lpb_pkg::OccW'(occ);
    return r;
  endfunction

  logic out_free;
  assign out_free = !ov_q || out_ch.ready;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SHIFT) begin
      if (sh_q + NW'(1) < sh_end_q)
        lru_q[sh_q[PW-1:0]] <= lru_q[PW'(sh_q + NW'(1))];
      else if (ins_q)
        lru_q[sh_q[PW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; res_q <= '0;
    end else if (state_q == S_EMIT && out_free) begin
      ov_q <= 1'b1; res_q <= work_q;
    end else if (out_ch.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    lpb_pkg::res_t w;
    if (!rst_ni) begin
      state_q <= S_IDLE; n_q <= '0; ptr_q <= '0; sum_q <= '0; hits_q <= '0;
      found_q <= 1'b0; pos_q <= '0; sh_q <= '0; sh_end_q <= '0;
      ins_q <= 1'b0; miss_reply_q <= 1'b0; after_q <= A_DONE;
      fetches_q <= '0; target_q <= '0; key_q <= '0; cmd_q <= '0; work_q <= '0;
    end else begin
      w = work_q;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            key_q <= (cmd_i.op == lpb_pkg::OP_PREFETCH) ? ptr_q : {1'b0, cmd_i.index};
            pos_q <= '0; found_q <= 1'b0; fetches_q <= '0;
            miss_reply_q <= 1'b0;
            target_q <= ({1'b0, cmd_i.index} > count_i - 13'd1) ?
                        count_i - 13'd1 : {1'b0, cmd_i.index};
            if (cmd_i.op == lpb_pkg::OP_PREFETCH) begin
              state_q <= S_PF;
            end else if (cmd_i.op == lpb_pkg::OP_ACCESS && cmd_i.oor) begin
              w = blank(n_q, sum_q, hits_q);
              w.kind = lpb_pkg::KIND_REPLY;
              w.range_err = 1'b1;
              w.last = 1'b1;
              after_q <= A_DONE;
              state_q <= S_EMIT;
            end else if (cmd_i.op == lpb_pkg::OP_NONE) begin
              w = blank(n_q, sum_q, hits_q);
              w.kind = lpb_pkg::KIND_DONE;
              w.last = 1'b1;
              after_q <= A_DONE;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_PF: begin
          if (count_i == '0 || ptr_q > target_q || ptr_q >= count_i) begin
            w = blank(n_q, sum_q, hits_q);
            w.kind = lpb_pkg::KIND_DONE;
            w.last = 1'b1;
            after_q <= A_DONE;
            state_q <= S_EMIT;
          end else begin
            key_q <= ptr_q;
            pos_q <= '0; found_q <= 1'b0;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (pos_q < n_q && match) begin
            found_q <= 1'b1;
            state_q <= S_ACT;
          end else if (pos_q >= n_q || pos_q == NW'(MAX_ENTRIES - 1)) begin
            if (!(pos_q < n_q && match) && pos_q < n_q) pos_q <= pos_q + NW'(1);
            state_q <= S_ACT;
          end else begin
            pos_q <= pos_q + NW'(1);
          end
        end
        S_ACT: begin
          w = blank(n_q, sum_q, hits_q);
          if (cmd_q.op == lpb_pkg::OP_RELEASE) begin
            w.kind = lpb_pkg::KIND_DONE;
            w.last = 1'b1;
            w.occupancy = lpb_pkg::OccW'(found_q ? n_q - NW'(1) : n_q);
            after_q <= A_DONE;
            if (found_q) begin
              sh_q <= pos_q; sh_end_q <= n_q; ins_q <= 1'b0;
              n_q <= n_q - NW'(1);
              state_q <= S_SHIFT;
            end else state_q <= S_EMIT;
          end else if (cmd_q.op == lpb_pkg::OP_ACCESS && found_q) begin
            sum_q <= sum_sat;
            hits_q <= hits_sat;
            w.total_reuse = sum_sat;
            w.reuse_hits = hits_sat;
            w.kind = lpb_pkg::KIND_REPLY;
            w.hit = 1'b1;
            w.reuse_distance = hit_depth;
            w.last = 1'b1;
            after_q <= A_DONE;
            sh_q <= pos_q; sh_end_q <= n_q; ins_q <= 1'b1;
            state_q <= S_SHIFT;
          end else if (cmd_q.op == lpb_pkg::OP_PREFETCH && found_q) begin
            ptr_q <= ptr_q + 13'd1;
            state_q <= S_PF;
          end else if (cmd_q.op == lpb_pkg::OP_PREFETCH &&
                       fetches_q >= BW'(MAX_PREFETCH_BURST)) begin
            w.kind = lpb_pkg::KIND_DONE;
            w.clamped = 1'b1;
            w.last = 1'b1;
            after_q <= A_DONE;
            state_q <= S_EMIT;
          end else begin
            w.kind = lpb_pkg::KIND_FETCH;
            w.fetch_group = {1'b0, base_i} + {4'd0, key_q};
            w.evicted = evict;
            w.evicted_index = evict ? lru_q[0][lpb_pkg::IdxW-1:0] : '0;
            if (cmd_q.op == lpb_pkg::OP_PREFETCH) begin
              fetches_q <= fetches_q + BW'(1);
              ptr_q <= ptr_q + 13'd1;
              after_q <= A_PF;
            end else begin
              after_q <= A_DONE;
              miss_reply_q <= 1'b1;
            end
            if (evict) begin
              sh_q <= '0; sh_end_q <= n_q; ins_q <= 1'b1;
              w.occupancy = lpb_pkg::OccW'(n_q);
              state_q <= S_SHIFT;
            end else if (n_q < NW'(MAX_ENTRIES)) begin
              sh_q <= n_q; sh_end_q <= n_q + NW'(1); ins_q <= 1'b1;
              n_q <= n_q + NW'(1);
              w.occupancy = lpb_pkg::OccW'(n_q + NW'(1));
              state_q <= S_SHIFT;
            end else state_q <= S_EMIT;
          end
        end
        S_SHIFT: begin
          if (sh_q + NW'(1) >= sh_end_q) state_q <= S_EMIT;
          else sh_q <= sh_q + NW'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            if (miss_reply_q) begin
              miss_reply_q <= 1'b0;
              w = blank(n_q, sum_q, hits_q);
              w.kind = lpb_pkg::KIND_REPLY;
              w.last = 1'b1;
            end else if (after_q == A_PF) begin
              state_q <= S_PF;
            end else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      work_q <= w;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NW'(MAX_ENTRIES))
    else $error("occupancy beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ch.ready) |=> ov_q && $stable(res_q)) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.hit) |-> res_q.kind == lpb_pkg::KIND_REPLY) else $error("bad hit");
endmodule

### hdl/lru_prefetch_buffer_reuse_distance.sv
// LRU prefetch buffer with reuse-distance totals, top level.
// Depends on lpb_pkg, lpb_if, lpb_front, lpb_back.
//
// Channels: in_ch carries (operation, index); out_ch carries result
// transactions of type lpb_pkg::res_t. APB port writes base_group (0x0),
// group_count (0x4) and capacity (0x8); the user must write them only
// while idle, as the block itself does not enforce it. The front
// range-checks and queues up to two items; the back walks the LRU store
// one entry a cycle. An access hit goes through search, act, reorder one
// entry a cycle, emit. A miss gives its fetch, then the reply. Prefetch
// fetches each absent index up to the target and skips resident ones.
// Release and unused opcodes give one done result.
// Reset clears occupancy, pointer and totals; capacity returns to 4.
// A stalled receiver holds the result register; the back stops and the
// front queue fills, then in_ch ready drops.
module lru_prefetch_buffer_reuse_distance #(
  parameter int unsigned MAX_ENTRIES        = 16,
  parameter int unsigned INDEX_LIMIT        = 4096,
  parameter int unsigned MAX_PREFETCH_BURST = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpb_in_if.sink      in_ch,
  lpb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] base_q;
  logic [12:0] count_q;
  logic [4:0]  cap_q;
  logic [12:0] count_eff;
  logic cmd_valid, cmd_ready;
  lpb_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign count_eff = ({19'd0, count_q} > INDEX_LIMIT) ? 13'(INDEX_LIMIT) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; count_q <= '0; cap_q <= 5'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        lpb_pkg::REG_BASE:  base_q  <= pwdata[15:0];
        lpb_pkg::REG_COUNT: count_q <= pwdata[12:0];
        lpb_pkg::REG_CAP:   cap_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lpb_pkg::REG_BASE:  prdata = {16'd0, base_q};
      lpb_pkg::REG_COUNT: prdata = {19'd0, count_q};
      lpb_pkg::REG_CAP:   prdata = {27'd0, cap_q};
      default:            prdata = '0;
    endcase
  end

  lpb_front u_front (
    .clk_i, .rst_ni, .in_ch, .count_i(count_eff),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  lpb_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_PREFETCH_BURST(MAX_PREFETCH_BURST)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .base_i(base_q), .count_i(count_eff), .cap_i(cap_q), .out_ch
  );
endmodule

### tb/lru_prefetch_buffer_reuse_distance_test.sv
// Testbench for the LRU prefetch buffer with reuse-distance totals.
// Drives commands and APB register writes, predicts every result transaction
// and checks it field by field. Depends on lpb_pkg, lpb_if and the RTL top.
module lru_prefetch_buffer_reuse_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxLimit = 4096;
  localparam int unsigned Burst = 63;
  localparam logic [47:0] TotMax = 48'hFFFF_FFFF_FFFF;

  class reuse_tracker;
    lpb_pkg::res_t expected_results[$];
    int errors;
    logic [15:0] base_group;
    logic [12:0] group_count;
    logic [4:0] capacity;
    logic [11:0] lru[Entries];
    int unsigned resident;
    int unsigned pointer;
    logic [47:0] reuse_sum, hit_count;

    function new();
      errors = 0;
      base_group = 0;
      group_count = 0;
      capacity = 4;
      resident = 0;
      pointer = 0;
      reuse_sum = 0;
      hit_count = 0;
    endfunction

    function int unsigned live_count();
      return (group_count > IdxLimit) ? IdxLimit : group_count;
    endfunction

    function int unsigned live_cap();
      int unsigned c;
      c = (capacity == 0) ? 1 : capacity;
      return (c > Entries) ? Entries : c;
    endfunction

    function int find(int unsigned idx);
      for (int i = 0; i < resident; i++) if (lru[i] == idx) return i;
      return -1;
    endfunction

    function void drop(int unsigned pos);
      for (int unsigned i = pos; i + 1 < resident; i++) lru[i] = lru[i + 1];
      resident--;
    endfunction

    function logic [47:0] sat_inc(logic [47:0] a, int unsigned b);
      logic [48:0] s;
      s = {1'b0, a} + b;
      return (s > {1'b0, TotMax}) ? TotMax : s[47:0];
    endfunction

    function void push(lpb_pkg::kind_e kind, logic [16:0] fg, logic ev,
                       logic [11:0] evi, logic hit, int unsigned reuse, logic oor,
                       logic clamp, logic last);
      lpb_pkg::res_t r;
      r.kind = kind;
      r.fetch_group = fg;
      r.evicted = ev;
      r.evicted_index = evi;
      r.hit = hit;
      r.reuse_distance = (reuse > 15) ? 4'd15 : reuse[3:0];
      r.total_reuse = reuse_sum;
      r.reuse_hits = hit_count;
      r.range_err = oor;
      r.clamped = clamp;
      r.occupancy = resident[4:0];
      r.last = last;
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void fetch(int unsigned idx);
      logic ev;
      logic [11:0] evi;
      ev = 0;
      evi = 0;
      if (resident >= live_cap() && resident > 0) begin
        ev = 1;
        evi = lru[0];
        drop(0);
      end
      if (resident < Entries) begin
        lru[resident] = idx[11:0];
        resident++;
      end
      push(lpb_pkg::KIND_FETCH, 17'(base_group) + 17'(idx), ev, evi, 0, 0, 0, 0, 0);
    endfunction

    function void note_request(lpb_pkg::op_e op, logic [11:0] idx);
      int unsigned cnt, target, fetches, reuse;
      int pos;
      logic clamp;
      cnt = live_count();
      case (op)
        lpb_pkg::OP_ACCESS: begin
          if (idx >= cnt) begin
            push(lpb_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 1, 0, 1);
          end else begin
            pos = find(idx);
            if (pos >= 0) begin
              reuse = resident - 1 - pos;
              reuse_sum = sat_inc(reuse_sum, reuse);
              hit_count = sat_inc(hit_count, 1);
              drop(pos);
              lru[resident] = idx;
              resident++;
              push(lpb_pkg::KIND_REPLY, 0, 0, 0, 1, reuse, 0, 0, 1);
            end else begin
              fetch(idx);
              push(lpb_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, 0, 1);
            end
          end
        end
        lpb_pkg::OP_PREFETCH: begin
          fetches = 0;
          clamp = 0;
          if (cnt > 0) begin
            target = (idx > cnt - 1) ? cnt - 1 : idx;
            while (pointer <= target && pointer < cnt) begin
              if (find(pointer) < 0) begin
                if (fetches >= Burst) begin
                  clamp = 1;
                  break;
                end
                fetch(pointer);
                fetches++;
              end
              pointer++;
            end
          end
          push(lpb_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, clamp, 1);
        end
        default: begin
          if (op == lpb_pkg::OP_RELEASE) begin
            pos = find(idx);
            if (pos >= 0) drop(pos);
          end
          push(lpb_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void cmp(string name, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(lpb_pkg::res_t got);
      lpb_pkg::res_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      cmp("kind", e.kind, got.kind);
      cmp("fetch_group", e.fetch_group, got.fetch_group);
      cmp("evicted", e.evicted, got.evicted);
      cmp("evicted_index", e.evicted_index, got.evicted_index);
      cmp("hit", e.hit, got.hit);
      cmp("reuse_distance", e.reuse_distance, got.reuse_distance);
      cmp("total_reuse", e.total_reuse, got.total_reuse);
      cmp("reuse_hits", e.reuse_hits, got.reuse_hits);
      cmp("range_err", e.range_err, got.range_err);
      cmp("clamped", e.clamped, got.clamped);
      cmp("occupancy", e.occupancy, got.occupancy);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  bit no_idle = 0;
  reuse_tracker tracker = new();

  lpb_in_if in_ch();
  lpb_out_if out_ch();

  lru_prefetch_buffer_reuse_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.operation = lpb_pkg::OP_NONE;
    in_ch.index = 0;
    out_ch.ready = 0;
  end

  task automatic write_reg(logic [1:0] reg_id, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    case (reg_id)
      lpb_pkg::REG_BASE: tracker.base_group = value[15:0];
      lpb_pkg::REG_COUNT: tracker.group_count = value[12:0];
      default: tracker.capacity = value[4:0];
    endcase
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic configure(logic [15:0] base, logic [12:0] cnt, logic [4:0] cap);
    @(negedge clk_i);
    in_ch.valid <= 0;
    do @(posedge clk_i); while (tracker.expected_results.size() != 0);
    repeat (60) @(posedge clk_i);
    write_reg(lpb_pkg::REG_BASE, base);
    write_reg(lpb_pkg::REG_COUNT, cnt);
    write_reg(lpb_pkg::REG_CAP, cap);
  endtask

  task automatic send(lpb_pkg::op_e op, logic [11:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_request(op, idx);
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned r, cnt, t;
    lpb_pkg::op_e op;
    logic [11:0] idx;
    cnt = tracker.live_count();
    for (int unsigned n = 0; n < items; n++) begin
      no_idle = (n % 12) < 3;
      r = $urandom_range(0, 99);
      op = (r < 60) ? lpb_pkg::OP_ACCESS : (r < 78) ? lpb_pkg::OP_PREFETCH :
           (r < 95) ? lpb_pkg::OP_RELEASE : lpb_pkg::OP_NONE;
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, 4095);
      end else if (op == lpb_pkg::OP_PREFETCH) begin
        t = tracker.pointer + $urandom_range(0, 80);
        idx = (t > 4095) ? 12'd4095 : t[11:0];
      end else if (tracker.resident > 0 && $urandom_range(0, 1) == 1) begin
        idx = tracker.lru[$urandom_range(0, tracker.resident - 1)];
      end else begin
        t = $urandom_range(0, (cnt < 40 ? cnt : 40) + 2);
        idx = t[11:0];
      end
      send(op, idx);
    end
  endtask

  // result side: random backpressure with occasional stall-free stretches
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.data);
        stall = no_idle ? 0 : $urandom_range(0, 13);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 0;
        stall--;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // no valid groups, capacity zero treated as one
    configure(16'hFFFF, 13'd0, 5'd0);
    send(lpb_pkg::OP_ACCESS, 12'd0);
    send(lpb_pkg::OP_PREFETCH, 12'd4095);
    send(lpb_pkg::OP_RELEASE, 12'd5);
    send(lpb_pkg::OP_NONE, 12'd4095);

    configure(16'd0, 13'd16, 5'd16);
    send(lpb_pkg::OP_ACCESS, 12'd3);
    send(lpb_pkg::OP_ACCESS, 12'd7);
    send(lpb_pkg::OP_ACCESS, 12'd3);
    send(lpb_pkg::OP_ACCESS, 12'd4095);
    send(lpb_pkg::OP_PREFETCH, 12'd4095);
    send(lpb_pkg::OP_ACCESS, 12'd0);
    send(lpb_pkg::OP_ACCESS, 12'd15);
    send(lpb_pkg::OP_RELEASE, 12'd9);
    send(lpb_pkg::OP_RELEASE, 12'd9);
    send(lpb_pkg::OP_ACCESS, 12'd9);
    send(lpb_pkg::OP_ACCESS, 12'd16);

    // capacity lowered below occupancy
    configure(16'hFFFF, 13'd4095, 5'd1);
    send(lpb_pkg::OP_ACCESS, 12'd4094);
    send(lpb_pkg::OP_ACCESS, 12'd4095);
    send(lpb_pkg::OP_PREFETCH, 12'd100);
    send(lpb_pkg::OP_PREFETCH, 12'd4095);
    send(lpb_pkg::OP_NONE, 12'd0);

    configure(16'd1234, 13'd24, 5'd4);
    random_phase(30);
    configure(16'hFFFF, 13'd300, 5'd31);
    random_phase(30);
    configure(16'd7, 13'd8191, 5'd16);
    random_phase(30);
    configure(16'd500, 13'd4096, 5'd3);
    random_phase(30);
    configure(16'd0, 13'd40, 5'd0);
    random_phase(30);

    @(negedge clk_i);
    in_ch.valid <= 0;
    do @(posedge clk_i); while (tracker.expected_results.size() != 0);
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule
